// ===== hw/rtl/clpe_pkg.sv =====
// clpe_pkg: constants, payload structs and controller/datapath links
// for the calibrated line position estimator; no dependencies
package clpe_pkg;

  localparam int NUM_SENSORS     = 5;
  localparam int CAL_SAMPLES_DEF = 10;

  localparam int RAW_W   = 10;
  localparam int POS_W   = 12;
  localparam int CNT_W   = 4;
  localparam int SIDX_W  = $clog2(NUM_SENSORS);

  localparam int FULL_SCALE  = 1000;
  localparam int SEEN_LEVEL  = 200;
  localparam int NOISE_LEVEL = 50;
  localparam int RAW_MAX     = 1023;

  localparam int MAX_POS = (NUM_SENSORS - 1) * FULL_SCALE;
  localparam int MID_POS = MAX_POS / 2;

  // shared restoring divider: quotient bits, divisor width, accumulator
  localparam int DIV_QW = POS_W;
  localparam int SUM_W  = $clog2(NUM_SENSORS * FULL_SCALE + 1);
  localparam int DIVR_W = (SUM_W > RAW_W) ? SUM_W : RAW_W;
  localparam int ACC_W  = 1 + DIVR_W + DIV_QW;
  localparam int WSUM_W = $clog2(FULL_SCALE * MAX_POS * NUM_SENSORS + 1);
  localparam int PROD_W = $clog2(RAW_MAX * FULL_SCALE + 1);
  localparam int STEP_W = $clog2(DIV_QW);

  typedef struct packed {
    logic             req_type;
    logic [RAW_W-1:0] raw_sensor_0;
    logic [RAW_W-1:0] raw_sensor_1;
    logic [RAW_W-1:0] raw_sensor_2;
    logic [RAW_W-1:0] raw_sensor_3;
    logic [RAW_W-1:0] raw_sensor_4;
    logic             line_is_white;
  } clpe_in_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [RAW_W-1:0] cal_value_0;
    logic [RAW_W-1:0] cal_value_1;
    logic [RAW_W-1:0] cal_value_2;
    logic [RAW_W-1:0] cal_value_3;
    logic [RAW_W-1:0] cal_value_4;
    logic             line_seen;
    logic             calibration_done;
  } clpe_out_t;

  typedef struct packed {
    logic              capture;
    logic              cal_update;
    logic              widen;
    logic              div_step;
    logic              sens_done;
    logic              pos_start;
    logic              pos_done;
    logic              load_out;
    logic [SIDX_W-1:0] sidx;
  } clpe_cmd_t;

  typedef struct packed {
    logic direct;
    logic seen;
    logic out_busy;
  } clpe_sts_t;

  function automatic logic [POS_W-1:0] sensor_weight(input logic [SIDX_W-1:0] idx);
    return POS_W'(int'(idx) * FULL_SCALE);
  endfunction

endpackage

// ===== hw/rtl/calibrated_line_position_estimator.sv =====
// calibrated_line_position_estimator: top level, controller plus datapath
// depends on clpe_pkg, clpe_ctrl, clpe_dp
//
//   channel  ports                       beat moves
//   in       in_valid in_ready in_data   one scan, read or calibration sample
//   out      out_valid out_ready out_data one result per scan
//
// a position read runs from accept to result, and no new scan is accepted
// until its result is loaded: per sensor a widen step, 12 steps of the shared
// restoring divider (skipped when the range is empty or the raw value is at
// the ceiling) and a finish step, then 12 more divider steps for the weighted
// average when a line is seen, a position step, a store step and the output load
// a calibration sample takes an update step and the output load, batch done in parallel
// reset is synchronous, active low; floor/ceiling and batch count clear at once
// a held result sits in the output register while the next scan is accepted
module calibrated_line_position_estimator #(
  parameter int CAL_SAMPLES = clpe_pkg::CAL_SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  clpe_pkg::clpe_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output clpe_pkg::clpe_out_t out_data
);

  // command and status between sequencer and datapath
  clpe_pkg::clpe_cmd_t cmd;
  clpe_pkg::clpe_sts_t sts;

  clpe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .req_type (in_data.req_type),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // calibration store, scaling and the shared divider
  clpe_dp #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/clpe_ctrl.sv =====
// clpe_ctrl: sequencer for the line position estimator
// depends on clpe_pkg for command and status structs
module clpe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 req_type,
  input  clpe_pkg::clpe_sts_t  sts,
  output logic                 in_ready,
  output clpe_pkg::clpe_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_CAL, S_WIDEN, S_DIV, S_SDONE, S_POS, S_POSDONE, S_EMIT
  } state_t;

  localparam logic [clpe_pkg::SIDX_W-1:0] LAST_SIDX =
    clpe_pkg::SIDX_W'(clpe_pkg::NUM_SENSORS - 1);
  localparam logic [clpe_pkg::STEP_W-1:0] LAST_STEP =
    clpe_pkg::STEP_W'(clpe_pkg::DIV_QW - 1);

  state_t                        state_r;
  logic [clpe_pkg::SIDX_W-1:0]   sidx_r;
  logic [clpe_pkg::STEP_W-1:0]   step_r;
  logic                          pos_phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sidx_r      <= '0;
      step_r      <= '0;
      pos_phase_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          sidx_r      <= '0;
          pos_phase_r <= 1'b0;
          if (in_valid) begin
            state_r <= req_type ? S_CAL : S_WIDEN;
          end
        end
        S_CAL: state_r <= S_EMIT;
        S_WIDEN: begin
          step_r  <= '0;
          state_r <= sts.direct ? S_SDONE : S_DIV;
        end
        S_DIV: begin
          step_r <= step_r + 1'b1;
          if (step_r == LAST_STEP) begin
            state_r <= pos_phase_r ? S_POSDONE : S_SDONE;
          end
        end
        S_SDONE: begin
          if (sidx_r == LAST_SIDX) begin
            state_r <= S_POS;
          end else begin
            sidx_r  <= sidx_r + 1'b1;
            state_r <= S_WIDEN;
          end
        end
        S_POS: begin
          step_r      <= '0;
          pos_phase_r <= 1'b1;
          state_r     <= sts.seen ? S_DIV : S_POSDONE;
        end
        S_POSDONE: state_r <= S_EMIT;
        S_EMIT: begin
          if (!sts.out_busy) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.sidx       = sidx_r;
    cmd.capture    = (state_r == S_IDLE) && in_valid;
    cmd.cal_update = (state_r == S_CAL);
    cmd.widen      = (state_r == S_WIDEN);
    cmd.div_step   = (state_r == S_DIV);
    cmd.sens_done  = (state_r == S_SDONE);
    cmd.pos_start  = (state_r == S_POS);
    cmd.pos_done   = (state_r == S_POSDONE);
    cmd.load_out   = (state_r == S_EMIT) && !sts.out_busy;
  end

  a_sidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    sidx_r <= LAST_SIDX)
    else $error("sensor index past last sensor");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted beat did not start work");

endmodule

// ===== hw/rtl/clpe_dp.sv =====
// clpe_dp: calibration store, scaling, weighted sum, shared divider and
// output register; depends on clpe_pkg
module clpe_dp #(
  parameter int CAL_SAMPLES = clpe_pkg::CAL_SAMPLES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  clpe_pkg::clpe_in_t   in_data,
  input  clpe_pkg::clpe_cmd_t  cmd,
  output clpe_pkg::clpe_sts_t  sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output clpe_pkg::clpe_out_t  out_data
);

  localparam int N     = clpe_pkg::NUM_SENSORS;
  localparam int RW    = clpe_pkg::RAW_W;
  localparam int PW    = clpe_pkg::POS_W;
  localparam int QW    = clpe_pkg::DIV_QW;
  localparam int AW    = clpe_pkg::ACC_W;
  localparam int DW    = clpe_pkg::DIVR_W;
  localparam int TW    = RW + PW;
  localparam logic [RW-1:0] FULL  = RW'(clpe_pkg::FULL_SCALE);
  localparam logic [RW-1:0] SEEN  = RW'(clpe_pkg::SEEN_LEVEL);
  localparam logic [RW-1:0] NOISE = RW'(clpe_pkg::NOISE_LEVEL);
  localparam logic [RW-1:0] RMAX  = RW'(clpe_pkg::RAW_MAX);
  localparam logic [PW-1:0] MAXP  = PW'(clpe_pkg::MAX_POS);
  localparam logic [PW-1:0] MIDP  = PW'(clpe_pkg::MID_POS);
  localparam logic [clpe_pkg::CNT_W-1:0] NCAL = clpe_pkg::CNT_W'(CAL_SAMPLES);

  logic [RW-1:0] raw_r   [N];
  logic [RW-1:0] floor_r [N];
  logic [RW-1:0] ceil_r  [N];
  logic [RW-1:0] blow_r  [N];
  logic [RW-1:0] bhigh_r [N];
  logic [RW-1:0] cal_r   [N];

  logic                          white_r, is_cal_r, done_r, seen_r, direct_r;
  logic [clpe_pkg::CNT_W-1:0]    bcnt_r;
  logic [PW-1:0]                 last_pos_r, pos_r;
  logic [clpe_pkg::WSUM_W-1:0]   wsum_r;
  logic [clpe_pkg::SUM_W-1:0]    sum_r;
  logic [AW-1:0]                 acc_r;
  logic [DW-1:0]                 dvs_r;
  logic [RW-1:0]                 dval_r;
  logic                          out_valid_r;
  clpe_pkg::clpe_out_t           out_r;

  // widen and scale set-up for the selected sensor
  logic [RW-1:0]                 raw_sel, lo_nxt, hi_nxt, nmag, dmag;
  logic                          same, dneg, direct_nxt;
  logic [clpe_pkg::PROD_W-1:0]   prod;

  always_comb begin
    raw_sel    = raw_r[cmd.sidx];
    lo_nxt     = (raw_sel < floor_r[cmd.sidx]) ? raw_sel : floor_r[cmd.sidx];
    hi_nxt     = (raw_sel > ceil_r[cmd.sidx]) ? raw_sel : ceil_r[cmd.sidx];
    nmag       = raw_sel - lo_nxt;
    dmag       = hi_nxt - lo_nxt;
    same       = (hi_nxt == lo_nxt);
    dneg       = (hi_nxt < lo_nxt);
    direct_nxt = same || dneg || (nmag >= dmag);
    prod       = clpe_pkg::PROD_W'(nmag) * clpe_pkg::PROD_W'(FULL);
  end

  // sensor finish: value, white-line inversion, weighted term
  logic [RW-1:0] v, vadj;
  logic [TW-1:0] term;

  always_comb begin
    v    = direct_r ? dval_r : acc_r[RW-1:0];
    vadj = white_r ? (FULL - v) : v;
    term = TW'(vadj) * TW'(clpe_pkg::sensor_weight(cmd.sidx));
  end

  // one restoring division step
  logic [AW-1:0] acc_sh, acc_step;
  logic [DW:0]   rem_hi;

  always_comb begin
    acc_sh   = {acc_r[AW-2:0], 1'b0};
    rem_hi   = acc_sh[AW-1:QW];
    acc_step = acc_sh;
    if (rem_hi >= {1'b0, dvs_r}) begin
      acc_step = {rem_hi - {1'b0, dvs_r}, acc_sh[QW-1:1], 1'b1};
    end
  end

  // batch update for a calibration beat
  logic [clpe_pkg::CNT_W-1:0] bcnt_nxt;
  logic                       batch_end;
  logic [RW-1:0]              blow_nxt  [N];
  logic [RW-1:0]              bhigh_nxt [N];

  always_comb begin
    bcnt_nxt  = bcnt_r + 1'b1;
    batch_end = (bcnt_nxt >= NCAL);
    for (int i = 0; i < N; i++) begin
      blow_nxt[i]  = ((bcnt_r == '0) || (raw_r[i] < blow_r[i])) ? raw_r[i] : blow_r[i];
      bhigh_nxt[i] = ((bcnt_r == '0) || (raw_r[i] > bhigh_r[i])) ? raw_r[i] : bhigh_r[i];
    end
  end

  logic [PW-1:0] pos_nxt;
  assign pos_nxt = seen_r ? acc_r[PW-1:0] : ((last_pos_r < MIDP) ? '0 : MAXP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        floor_r[i] <= '0;
        ceil_r[i]  <= RMAX;
      end
      bcnt_r     <= '0;
      last_pos_r <= '0;
    end else begin
      if (cmd.cal_update) begin
        for (int i = 0; i < N; i++) begin
          blow_r[i]  <= blow_nxt[i];
          bhigh_r[i] <= bhigh_nxt[i];
          if (batch_end) begin
            if (blow_nxt[i] > floor_r[i]) floor_r[i] <= blow_nxt[i];
            if (bhigh_nxt[i] < ceil_r[i]) ceil_r[i] <= bhigh_nxt[i];
          end
        end
        bcnt_r <= batch_end ? '0 : bcnt_nxt;
      end
      if (cmd.widen) begin
        floor_r[cmd.sidx] <= lo_nxt;
        ceil_r[cmd.sidx]  <= hi_nxt;
      end
      if (cmd.pos_done) begin
        last_pos_r <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_r[0] <= in_data.raw_sensor_0;
      raw_r[1] <= in_data.raw_sensor_1;
      raw_r[2] <= in_data.raw_sensor_2;
      raw_r[3] <= in_data.raw_sensor_3;
      raw_r[4] <= in_data.raw_sensor_4;
      white_r  <= in_data.line_is_white;
      is_cal_r <= in_data.req_type;
      wsum_r   <= '0;
      sum_r    <= '0;
      seen_r   <= 1'b0;
    end
    if (cmd.cal_update) begin
      done_r <= batch_end;
    end
    if (cmd.widen) begin
      acc_r    <= AW'(prod);
      dvs_r    <= DW'(dmag);
      direct_r <= direct_nxt;
      dval_r   <= (!same && !dneg) ? FULL : '0;
    end
    if (cmd.div_step) begin
      acc_r <= acc_step;
    end
    if (cmd.sens_done) begin
      cal_r[cmd.sidx] <= v;
      if (vadj > SEEN) seen_r <= 1'b1;
      if (vadj > NOISE) begin
        wsum_r <= wsum_r + clpe_pkg::WSUM_W'(term);
        sum_r  <= sum_r + clpe_pkg::SUM_W'(vadj);
      end
    end
    if (cmd.pos_start) begin
      acc_r <= AW'(wsum_r);
      dvs_r <= DW'(sum_r);
    end
    if (cmd.pos_done) begin
      pos_r <= pos_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (is_cal_r) begin
        out_r.position         <= '0;
        out_r.cal_value_0      <= '0;
        out_r.cal_value_1      <= '0;
        out_r.cal_value_2      <= '0;
        out_r.cal_value_3      <= '0;
        out_r.cal_value_4      <= '0;
        out_r.line_seen        <= 1'b0;
        out_r.calibration_done <= done_r;
      end else begin
        out_r.position         <= pos_r;
        out_r.cal_value_0      <= cal_r[0];
        out_r.cal_value_1      <= cal_r[1];
        out_r.cal_value_2      <= cal_r[2];
        out_r.cal_value_3      <= cal_r[3];
        out_r.cal_value_4      <= cal_r[4];
        out_r.line_seen        <= seen_r;
        out_r.calibration_done <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign sts.direct   = direct_nxt;
  assign sts.seen     = seen_r;
  assign sts.out_busy = out_valid_r && !out_ready;

  a_batch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r < NCAL)
    else $error("batch count reached batch size");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && !out_ready))
    else $error("output register overwritten while held");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pos_done |=> (last_pos_r <= MAXP))
    else $error("position beyond last sensor");

endmodule

// ===== bench/clpe_checker.sv =====
`timescale 1ns / 1ps
// clpe_checker: watches both channels of the line position estimator,
// predicts each result from the accepted scans and compares; needs clpe_pkg
module clpe_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  clpe_pkg::clpe_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  clpe_pkg::clpe_out_t out_data,
  input  int                  cal_samples,
  output int                  fail_count,
  output int                  pending
);

  logic [clpe_pkg::RAW_W-1:0] floor_q [clpe_pkg::NUM_SENSORS];
  logic [clpe_pkg::RAW_W-1:0] ceil_q [clpe_pkg::NUM_SENSORS];
  logic [clpe_pkg::RAW_W-1:0] blo_q [clpe_pkg::NUM_SENSORS];
  logic [clpe_pkg::RAW_W-1:0] bhi_q [clpe_pkg::NUM_SENSORS];
  logic [clpe_pkg::POS_W-1:0] last_pos;
  logic [clpe_pkg::CNT_W-1:0] bcount;
  clpe_pkg::clpe_out_t expected_results [$];

  assign pending = expected_results.size();

  function automatic int unsigned scaled(int unsigned raw, int unsigned lo, int unsigned hi);
    int unsigned nmag, dmag, q;
    if (hi == lo) return 0;
    nmag = (raw < lo) ? lo - raw : raw - lo;
    dmag = (hi < lo) ? lo - hi : hi - lo;
    q = nmag * clpe_pkg::FULL_SCALE / dmag;
    if ((raw < lo) != (hi < lo)) return 0;
    return (q > clpe_pkg::FULL_SCALE) ? clpe_pkg::FULL_SCALE : q;
  endfunction

  task automatic predict_scan(input clpe_pkg::clpe_in_t s);
    logic [clpe_pkg::RAW_W-1:0] raw [clpe_pkg::NUM_SENSORS];
    int unsigned v, wsum, sum, pos;
    int unsigned cv [clpe_pkg::NUM_SENSORS];
    bit seen;
    clpe_pkg::clpe_out_t r;
    raw[0] = s.raw_sensor_0; raw[1] = s.raw_sensor_1; raw[2] = s.raw_sensor_2;
    raw[3] = s.raw_sensor_3; raw[4] = s.raw_sensor_4;
    r = '0;
    wsum = 0; sum = 0; seen = 0;
    if (s.req_type) begin
      for (int i = 0; i < clpe_pkg::NUM_SENSORS; i++) begin
        if (bcount == 0 || raw[i] < blo_q[i]) blo_q[i] = raw[i];
        if (bcount == 0 || raw[i] > bhi_q[i]) bhi_q[i] = raw[i];
      end
      bcount = bcount + 1'b1;
      if (bcount >= cal_samples) begin
        for (int i = 0; i < clpe_pkg::NUM_SENSORS; i++) begin
          if (blo_q[i] > floor_q[i]) floor_q[i] = blo_q[i];
          if (bhi_q[i] < ceil_q[i]) ceil_q[i] = bhi_q[i];
        end
        bcount = '0;
        r.calibration_done = 1'b1;
      end
    end else begin
      for (int i = 0; i < clpe_pkg::NUM_SENSORS; i++) begin
        if (raw[i] < floor_q[i]) floor_q[i] = raw[i];
        if (raw[i] > ceil_q[i]) ceil_q[i] = raw[i];
        v = scaled(raw[i], floor_q[i], ceil_q[i]);
        cv[i] = v;
        if (s.line_is_white) v = clpe_pkg::FULL_SCALE - v;
        if (v > clpe_pkg::SEEN_LEVEL) seen = 1;
        if (v > clpe_pkg::NOISE_LEVEL) begin
          wsum += v * i * clpe_pkg::FULL_SCALE;
          sum += v;
        end
      end
      if (seen) pos = (sum != 0) ? wsum / sum : 0;
      else pos = (last_pos < clpe_pkg::MID_POS) ? 0 : clpe_pkg::MAX_POS;
      last_pos = pos[clpe_pkg::POS_W-1:0];
      r.position = last_pos;
      r.cal_value_0 = cv[0][clpe_pkg::RAW_W-1:0];
      r.cal_value_1 = cv[1][clpe_pkg::RAW_W-1:0];
      r.cal_value_2 = cv[2][clpe_pkg::RAW_W-1:0];
      r.cal_value_3 = cv[3][clpe_pkg::RAW_W-1:0];
      r.cal_value_4 = cv[4][clpe_pkg::RAW_W-1:0];
      r.line_seen = seen;
    end
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic check_result(input clpe_pkg::clpe_out_t g);
    clpe_pkg::clpe_out_t e;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected beat", 1, 0);
      return;
    end
    e = expected_results.pop_front();
    if (g.position != e.position) report_mismatch("position", g.position, e.position);
    if (g.cal_value_0 != e.cal_value_0)
      report_mismatch("cal_value_0", g.cal_value_0, e.cal_value_0);
    if (g.cal_value_1 != e.cal_value_1)
      report_mismatch("cal_value_1", g.cal_value_1, e.cal_value_1);
    if (g.cal_value_2 != e.cal_value_2)
      report_mismatch("cal_value_2", g.cal_value_2, e.cal_value_2);
    if (g.cal_value_3 != e.cal_value_3)
      report_mismatch("cal_value_3", g.cal_value_3, e.cal_value_3);
    if (g.cal_value_4 != e.cal_value_4)
      report_mismatch("cal_value_4", g.cal_value_4, e.cal_value_4);
    if (g.line_seen != e.line_seen) report_mismatch("line_seen", g.line_seen, e.line_seen);
    if (g.calibration_done != e.calibration_done)
      report_mismatch("calibration_done", g.calibration_done, e.calibration_done);
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < clpe_pkg::NUM_SENSORS; i++) begin
        floor_q[i] = '0;
        ceil_q[i] = clpe_pkg::RAW_W'(clpe_pkg::RAW_MAX);
        blo_q[i] = '0;
        bhi_q[i] = '0;
      end
      last_pos = '0;
      bcount = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) predict_scan(in_data);
    end
  end
endmodule

// ===== bench/tb_calibrated_line_position_estimator.sv =====
`timescale 1ns / 1ps
// tb_calibrated_line_position_estimator: stimulus, idling and verdict for the
// line position estimator; depends on clpe_pkg, clpe_checker and the block
module tb_calibrated_line_position_estimator;

  localparam int WATCHDOG = 20000;

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_valid = 0;
  logic                in_ready;
  clpe_pkg::clpe_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 0;
  clpe_pkg::clpe_out_t out_data;
  int                  fail_count, pending;
  int                  send_idle_pct = 0, recv_idle_pct = 0;
  int                  stalled_cycles = 0;
  int                  reads_sent = 0, cals_sent = 0;

  always #6 clk = ~clk;

  calibrated_line_position_estimator dut (.*);

  clpe_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cal_samples(clpe_pkg::CAL_SAMPLES_DEF), .fail_count, .pending
  );

  // receiver stalls at random, percentage set per phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: counts cycles in which no beat moves on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) stalled_cycles <= 0;
    else stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("tb_calibrated_line_position_estimator: errors");
      $finish;
    end
  end

  // one beat: optional idle gap, then hold valid until accepted
  task automatic send_scan(input clpe_pkg::clpe_in_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (s.req_type) cals_sent++;
    else reads_sent++;
  endtask

  // drop valid after the last beat of a stretch
  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic clpe_pkg::clpe_in_t scan_of(input bit cal, input int r0, input int r1,
                                                 input int r2, input int r3, input int r4,
                                                 input bit white);
    clpe_pkg::clpe_in_t s;
    s.req_type = cal;
    s.raw_sensor_0 = clpe_pkg::RAW_W'(r0); s.raw_sensor_1 = clpe_pkg::RAW_W'(r1);
    s.raw_sensor_2 = clpe_pkg::RAW_W'(r2); s.raw_sensor_3 = clpe_pkg::RAW_W'(r3);
    s.raw_sensor_4 = clpe_pkg::RAW_W'(r4);
    s.line_is_white = white;
    return s;
  endfunction

  // dark line under a chosen sensor, light elsewhere, small noise; inverted for a white line
  function automatic clpe_pkg::clpe_in_t line_scan(input int centre, input bit white);
    clpe_pkg::clpe_in_t s;
    int r [clpe_pkg::NUM_SENSORS];
    for (int i = 0; i < clpe_pkg::NUM_SENSORS; i++) begin
      int d;
      d = (i > centre) ? i - centre : centre - i;
      r[i] = (d == 0) ? $urandom_range(1023, 800) :
             (d == 1) ? $urandom_range(800, 300) : $urandom_range(250, 0);
      if (white) r[i] = 1023 - r[i];
    end
    s = scan_of(0, r[0], r[1], r[2], r[3], r[4], white);
    return s;
  endfunction

  function automatic clpe_pkg::clpe_in_t random_scan(input bit cal);
    return scan_of(cal, $urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(1023), $urandom_range(1023), $urandom_range(1));
  endfunction

  // a full batch of calibration samples spread between two levels
  task automatic calibrate(input int lo, input int hi);
    for (int k = 0; k < clpe_pkg::CAL_SAMPLES_DEF; k++)
      send_scan(scan_of(1, $urandom_range(hi, lo), $urandom_range(hi, lo),
                        $urandom_range(hi, lo), $urandom_range(hi, lo),
                        $urandom_range(hi, lo), $urandom_range(1)));
  endtask

  task automatic random_phase(input int n);
    for (int k = 0; k < n; k++) begin
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) send_scan(line_scan($urandom_range(4), $urandom_range(1)));
      else if (pick < 75) send_scan(random_scan(0));
      else if (pick < 78) calibrate($urandom_range(300), $urandom_range(1023, 700));
      else send_scan(random_scan(1));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes against reset floor/ceiling, white and dark lines
    send_scan(scan_of(0, 0, 0, 0, 0, 0, 0));             // nothing seen, snap to 0
    send_scan(scan_of(0, 1023, 1023, 1023, 1023, 1023, 0));
    send_scan(scan_of(0, 0, 0, 0, 0, 1023, 0));          // right edge
    send_scan(scan_of(0, 0, 0, 0, 0, 0, 0));             // snap to far end
    send_scan(scan_of(0, 1023, 0, 0, 0, 0, 1));          // white line inverted
    send_scan(scan_of(0, 40, 60, 250, 60, 40, 0));       // noise threshold
    send_scan(scan_of(0, 682, 341, 0, 1023, 512, 1));
    // calibration batch with narrow ranges: floor equals ceiling on sensors 1, 3 and 4
    for (int k = 0; k < clpe_pkg::CAL_SAMPLES_DEF; k++)
      send_scan(scan_of(1, 600 + k, 600, 400 - k, 1023, 0, k[0]));
    send_scan(scan_of(0, 700, 500, 450, 1023, 0, 0));    // empty range on two sensors
    send_scan(scan_of(0, 550, 300, 398, 1023, 0, 1));
    send_scan(scan_of(1, 1023, 0, 1023, 0, 1023, 1));    // partial batch
    send_scan(scan_of(0, 1023, 1023, 1023, 0, 0, 0));

    send_idle_pct = 12; recv_idle_pct = 83;
    random_phase(350);

    // hold off until the block has drained
    release_input();
    while (pending != 0) @(posedge clk);
    send_idle_pct = 83; recv_idle_pct = 12;
    random_phase(350);

    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(350);

    release_input();
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d position reads and %0d calibration samples", reads_sent, cals_sent);
    if (fail_count == 0) begin
      $display("tb_calibrated_line_position_estimator: clean");
    end else begin
      $display("tb_calibrated_line_position_estimator: errors");
    end
    $finish;
  end
endmodule
